/* hdl/pvl_pkg.sv */
package pvl_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 5;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // compare width: holds count, position and count + 1 without overflow
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_MEMBER = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_POS  = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [POS_W-1:0]        position;
        logic signed [WORD_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        logic                     found;
        logic [1:0]               error_code;
        logic [LEN_W-1:0]         length;
        logic                     sorted;
    } t_out;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              rd;
        logic              member;
        logic [CMP_W-1:0]  pos_m1;
        logic [CMP_W-1:0]  count;
        logic [CMP_W-1:0]  n_count;
        logic [WORD_W-1:0] value;
    } t_cell_ctl;

    // per-cell status back to the top level
    typedef struct packed {
        logic              hit;
        logic              order_ok;
        logic [WORD_W-1:0] read_word;
    } t_cell_stat;

endpackage

/* hdl/pvl_cell.sv */
module pvl_cell import pvl_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [WORD_W-1:0] i_left_word,
    input  logic [WORD_W-1:0] i_right_word,
    input  logic [WORD_W-1:0] i_left_next,
    output logic [WORD_W-1:0] o_word,
    output logic [WORD_W-1:0] o_next,
    output t_cell_stat        o_stat
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [CMP_W-1:0]  idx;

    assign idx = CMP_W'(i_index);

    // next entry: take the new value, the left neighbor on insert, the right one on remove
    always_comb begin
        priority if (i_ctl.ins && idx == i_ctl.pos_m1) begin
            n_word = i_ctl.value;
        end else if (i_ctl.ins && idx > i_ctl.pos_m1 && idx <= i_ctl.count) begin
            n_word = i_left_word;
        end else if (i_ctl.rem && idx >= i_ctl.pos_m1 && (idx + 1'b1) < i_ctl.count) begin
            n_word = i_right_word;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // membership, read select and order check against the left neighbor
    always_comb begin
        o_stat.hit       = i_ctl.member && (idx < i_ctl.count) && (r_word == i_ctl.value);
        o_stat.read_word = (i_ctl.rd && idx == i_ctl.pos_m1) ? r_word : '0;
        o_stat.order_ok  = (idx == '0) || (idx >= i_ctl.n_count)
                           || !($signed(i_left_next) > $signed(n_word));
    end

    assign o_word = r_word;
    assign o_next = n_word;

endmodule

/* hdl/positional_value_list.sv */
// Ordered list of up to CAPACITY signed words held in a row of cells, one entry per cell.
// A command beat is taken whenever start is high; busy never rises, so one command can be
// issued every cycle. Insert, remove, read and membership each finish in the cycle they are
// taken: all cells shift and compare in parallel, and the result beat appears in the next
// cycle on o_result with o_valid high for exactly one cycle. The result cannot be held off,
// so it must be captured on that cycle. Reads and removes need a position from 1 to the
// length, inserts from 1 to length + 1; bad positions and inserts into a full list report
// an error and leave the list unchanged.
module positional_value_list import pvl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_valid,
    output t_out o_result
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_valid;
    t_out              r_out;
    t_out              n_out;

    logic              accept;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  pos_ext;
    logic              pos_ok_ins;
    logic              pos_ok_acc;
    logic              full;
    logic [1:0]        err;
    t_cell_ctl         ctl;

    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [WORD_W-1:0] cell_next [CAPACITY];
    t_cell_stat        cell_stat [CAPACITY];

    logic              any_hit;
    logic              all_ok;
    logic [WORD_W-1:0] rd_word;

    // every cycle can take a command beat
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign cnt_ext    = CMP_W'(r_count);
    assign pos_ext    = CMP_W'(i_item.position);
    assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);
    assign pos_ok_acc = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign full       = (cnt_ext >= CMP_W'(CAPACITY));

    // error decode, position check first
    always_comb begin
        unique case (i_item.operation)
            OP_INSERT: err = !pos_ok_ins ? ERR_POS : (full ? ERR_FULL : ERR_NONE);
            OP_REMOVE: err = pos_ok_acc ? ERR_NONE : ERR_POS;
            OP_READ:   err = pos_ok_acc ? ERR_NONE : ERR_POS;
            default:   err = ERR_NONE;
        endcase
    end

    // next length
    always_comb begin
        n_count = r_count;
        if (accept && err == ERR_NONE) begin
            if (i_item.operation == OP_INSERT) begin
                n_count = r_count + 1'b1;
            end else if (i_item.operation == OP_REMOVE) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    // broadcast to the cells
    always_comb begin
        ctl.ins     = accept && err == ERR_NONE && i_item.operation == OP_INSERT;
        ctl.rem     = accept && err == ERR_NONE && i_item.operation == OP_REMOVE;
        ctl.rd      = err == ERR_NONE && i_item.operation == OP_READ;
        ctl.member  = i_item.operation == OP_MEMBER;
        ctl.pos_m1  = pos_ext - 1'b1;
        ctl.count   = cnt_ext;
        ctl.n_count = CMP_W'(n_count);
        ctl.value   = i_item.value;
    end

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] left_next;
        logic [WORD_W-1:0] right_word;

        if (g == 0) begin : g_first
            assign left_word = '0;
            assign left_next = '0;
        end else begin : g_mid
            assign left_word = cell_word[g-1];
            assign left_next = cell_next[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_inner
            assign right_word = cell_word[g+1];
        end

        pvl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_index      (IDX_W'(g)),
            .i_left_word  (left_word),
            .i_right_word (right_word),
            .i_left_next  (left_next),
            .o_word       (cell_word[g]),
            .o_next       (cell_next[g]),
            .o_stat       (cell_stat[g])
        );
    end

    // combine cell status
    always_comb begin
        any_hit = 1'b0;
        all_ok  = 1'b1;
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            any_hit = any_hit | cell_stat[k].hit;
            all_ok  = all_ok & cell_stat[k].order_ok;
            rd_word = rd_word | cell_stat[k].read_word;
        end
    end

    // result beat
    always_comb begin
        n_out.read_word  = rd_word;
        n_out.found      = any_hit;
        n_out.error_code = err;
        n_out.length     = LEN_W'(n_count);
        n_out.sorted     = all_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

/* sim/positional_value_list_checker.sv */
module positional_value_list_checker import pvl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_item,
    input  logic i_valid,
    input  t_out i_result,
    output int   o_fail_count,
    output int   o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the list
    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int                       list_len;

    // results still owed by the block, oldest first
    t_out expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        list_len     = 0;
        foreach (list_words[k]) list_words[k] = '0;
    end

    // non-decreasing signed order over the live entries
    function automatic logic list_in_order();
        for (int k = 1; k < list_len; k++) begin
            if (list_words[k-1] > list_words[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // apply one command to the shadow list and build its result beat
    function automatic t_out apply_list_op(input t_in cmd);
        t_out res;
        int   p;
        p              = int'(cmd.position);
        res            = '0;
        res.error_code = ERR_NONE;
        case (cmd.operation)
            OP_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    res.error_code = ERR_POS;
                end else if (list_len >= CAPACITY) begin
                    res.error_code = ERR_FULL;
                end else begin
                    for (int k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
                    list_words[p-1] = cmd.value;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (p < 1 || p > list_len) begin
                    res.error_code = ERR_POS;
                end else begin
                    for (int k = p; k < list_len; k++) list_words[k-1] = list_words[k];
                    list_len--;
                end
            end
            OP_READ: begin
                if (p < 1 || p > list_len) res.error_code = ERR_POS;
                else res.read_word = list_words[p-1];
            end
            default: begin
                for (int k = 0; k < list_len; k++) begin
                    if (list_words[k] == cmd.value) res.found = 1'b1;
                end
            end
        endcase
        res.length = LEN_W'(list_len);
        res.sorted = list_in_order();
        return res;
    endfunction

    // field by field comparison of one result beat
    function automatic int compare_result(input t_out exp_res, input t_out act_res);
        int errs;
        errs = 0;
        if (act_res.read_word !== exp_res.read_word) begin
            $error("read_word: expected %0d, got %0d", exp_res.read_word, act_res.read_word);
            errs++;
        end
        if (act_res.found !== exp_res.found) begin
            $error("found: expected %0b, got %0b", exp_res.found, act_res.found);
            errs++;
        end
        if (act_res.error_code !== exp_res.error_code) begin
            $error("error_code: expected %0d, got %0d", exp_res.error_code,
                   act_res.error_code);
            errs++;
        end
        if (act_res.length !== exp_res.length) begin
            $error("length: expected %0d, got %0d", exp_res.length, act_res.length);
            errs++;
        end
        if (act_res.sorted !== exp_res.sorted) begin
            $error("sorted: expected %0b, got %0b", exp_res.sorted, act_res.sorted);
            errs++;
        end
        return errs;
    endfunction

    // watch both channels on every edge
    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            list_len = 0;
            foreach (list_words[k]) list_words[k] = '0;
            expected_results.delete();
        end else begin
            // command beat taken
            if (i_start && !i_busy) expected_results.push_back(apply_list_op(i_item));
            // result beat
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (compare_result(exp_res, i_result) != 0) o_fail_count++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* sim/positional_value_list_tb.sv */
module positional_value_list_tb;

    import pvl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    // length from the latest result, used only to aim positions
    logic [LEN_W-1:0] last_len = '0;

    // recently inserted words, reused for membership hits
    logic signed [WORD_W-1:0] word_pool [$];
    logic signed [WORD_W-1:0] ramp_word;
    logic                     no_idle;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    positional_value_list DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    positional_value_list_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (o_valid) last_len <= o_result.length;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("positional_value_list_tb NOT OK");
            $finish;
        end
    end

    // idle cycles ahead of a beat: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // present one command beat and hold it until taken
    task automatic send_cmd(input logic [1:0] op, input logic [POS_W-1:0] pos,
                            input logic signed [WORD_W-1:0] val);
        t_in cmd;
        int  gap;
        cmd.operation = op;
        cmd.position  = pos;
        cmd.value     = val;
        gap           = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy);
        if (op == OP_INSERT) begin
            word_pool.push_back(val);
            if (word_pool.size() > 32) void'(word_pool.pop_front());
        end
    endtask

    function automatic logic signed [WORD_W-1:0] pick_value(input int mode);
        case (mode)
            0: return $urandom;
            1: case ($urandom_range(0, 4))
                   0: return 32'sh8000_0000;
                   1: return 32'sh7fff_ffff;
                   2: return -32'sd1;
                   3: return 32'sd1;
                   default: return 32'sd0;
               endcase
            2: return $signed($urandom_range(0, 7)) - 4;
            default: begin
                if (word_pool.size() == 0) return $urandom;
                return word_pool[$urandom_range(0, word_pool.size() - 1)];
            end
        endcase
    endfunction

    // position aimed at the live range, sometimes any 5-bit value
    function automatic logic [POS_W-1:0] pick_pos(input logic [1:0] op);
        int top_pos;
        if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 31));
        top_pos = (op == OP_INSERT) ? int'(last_len) + 1 : int'(last_len);
        if (top_pos < 1) top_pos = 1;
        return POS_W'($urandom_range(1, top_pos));
    endfunction

    // one random command; style steers the mix of operations
    task automatic send_random(input int style);
        logic [1:0] op;
        int         r;
        r = $urandom_range(0, 99);
        case (style)
            0: op = (r < 60) ? OP_INSERT : (r < 75) ? OP_REMOVE : (r < 88) ? OP_READ : OP_MEMBER;
            1: op = (r < 20) ? OP_INSERT : (r < 70) ? OP_REMOVE : (r < 85) ? OP_READ : OP_MEMBER;
            2: op = 2'($urandom_range(0, 3));
            default: op = (r < 55) ? OP_INSERT : (r < 65) ? OP_REMOVE : (r < 82) ? OP_READ
                                                                          : OP_MEMBER;
        endcase
        if (style == 3 && op == OP_INSERT) begin
            // append an ascending run, now and then a step down
            if ($urandom_range(0, 19) == 0) ramp_word = ramp_word - $urandom_range(1, 5);
            else ramp_word = ramp_word + $urandom_range(0, 3);
            send_cmd(op, (last_len == LEN_W'(CAPACITY)) ? pick_pos(op) : last_len + 1'b1,
                     ramp_word);
        end else if (op == OP_MEMBER) begin
            send_cmd(op, POS_W'($urandom_range(0, 31)),
                     pick_value(($urandom_range(0, 1) == 0) ? 3 : $urandom_range(0, 2)));
        end else begin
            send_cmd(op, pick_pos(op), pick_value($urandom_range(0, 3)));
        end
    endtask

    initial begin
        int style;
        no_idle   = 1'b0;
        ramp_word = 32'sd0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bad positions on an empty list
        send_cmd(OP_INSERT, 5'd0, 32'sd5);
        send_cmd(OP_REMOVE, 5'd1, 32'sd0);
        send_cmd(OP_READ, 5'd1, 32'sd0);
        send_cmd(OP_MEMBER, 5'd0, 32'sh8000_0000);
        // extremes, in and out of order
        send_cmd(OP_INSERT, 5'd1, 32'sh7fff_ffff);
        send_cmd(OP_INSERT, 5'd1, 32'sh8000_0000);
        send_cmd(OP_INSERT, 5'd2, -32'sd1);
        send_cmd(OP_INSERT, 5'd4, 32'sd0);
        // fill to capacity at front and tail
        for (int k = 0; k < CAPACITY - 4; k++) begin
            send_cmd(OP_INSERT, (k % 3 == 0) ? 5'd1 : POS_W'(k + 5), $urandom);
        end
        // full list: valid position gives full, past the end gives bad position
        send_cmd(OP_INSERT, 5'd17, 32'sd7);
        send_cmd(OP_INSERT, 5'd18, 32'sd7);
        send_cmd(OP_READ, 5'd16, 32'sd0);
        send_cmd(OP_READ, 5'd17, 32'sd0);
        send_cmd(OP_REMOVE, 5'd31, 32'sd0);
        send_cmd(OP_MEMBER, 5'd31, 32'sh7fff_ffff);
        send_cmd(OP_REMOVE, 5'd16, 32'sd0);
        send_cmd(OP_REMOVE, 5'd1, 32'sd0);

        // random part in stretches of differing character
        style = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                style     = $urandom_range(0, 3);
                no_idle   = ($urandom_range(0, 3) == 0);
                ramp_word = $signed($urandom_range(0, 15)) - 8;
            end
            send_random(style);
        end
        start <= 1'b0;

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("positional_value_list_tb OK");
        end else begin
            $display("positional_value_list_tb NOT OK");
        end
        $finish;
    end

endmodule
